### src/bscf_pkg.sv
// ----------------------------------------------------------------------------
// bscf_pkg
// Shared types and constants for the bitmap set/clear/find-first block.
// ----------------------------------------------------------------------------
`default_nettype none

package bscf_pkg;

    localparam int MAX_BITS_DEF = 256;   // default store size
    localparam int ADDR_SPAN    = 256;   // span reachable by an 8-bit index
    localparam int CELL_BITS    = 8;     // bits held by one cell
    localparam int SUB_W        = 3;     // bit position inside a cell
    localparam int IDX_W        = 8;     // bit index width
    localparam int ID_W         = IDX_W - SUB_W;  // cell number width
    localparam int CNT_W        = 9;     // active count width
    localparam int FUNC_W       = 2;

    localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TEST  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Write broadcast to every cell
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             val;
    } wr_t;

    // Search record handed from cell to cell
    typedef struct packed {
        logic             test;
        logic [IDX_W-1:0] test_idx;
        logic             bit_value;
        logic [IDX_W-1:0] first_set;
        logic             set_found;
        logic [IDX_W-1:0] first_zero;
        logic             zero_found;
    } scan_t;

endpackage

`default_nettype wire

### src/bscf_cell.sv
// ----------------------------------------------------------------------------
// bscf_cell
// One byte of the bit store plus one step of the find-first search.
// ----------------------------------------------------------------------------
`default_nettype none

module bscf_cell #(
    parameter int CELL_ID = 0
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire bscf_pkg::wr_t               wr,
    input  wire logic [bscf_pkg::CNT_W-1:0]  active_count,
    input  wire logic                        scan_in_valid,
    input  wire bscf_pkg::scan_t             scan_in,
    output logic                             scan_out_valid,
    output bscf_pkg::scan_t                  scan_out
);

    localparam logic [bscf_pkg::ID_W-1:0]  MY_ID = CELL_ID[bscf_pkg::ID_W-1:0];
    localparam logic [bscf_pkg::CNT_W-1:0] BASE  =
        bscf_pkg::CNT_W'(CELL_ID * bscf_pkg::CELL_BITS);

    logic [bscf_pkg::CELL_BITS-1:0] bits_reg, bits_next;
    logic [bscf_pkg::CELL_BITS-1:0] act;
    logic [bscf_pkg::CELL_BITS-1:0] set_hits, zero_hits;
    logic [bscf_pkg::SUB_W-1:0]     set_pos, zero_pos;
    logic                           valid_reg;
    bscf_pkg::scan_t                rec_reg, rec_next;

    // Store update
    always_comb begin
        bits_next = bits_reg;
        if (wr.en && wr.idx[bscf_pkg::IDX_W-1:bscf_pkg::SUB_W] == MY_ID) begin
            bits_next[wr.idx[bscf_pkg::SUB_W-1:0]] = wr.val;
        end
    end

    // Active mask for this byte
    always_comb begin
        for (int j = 0; j < bscf_pkg::CELL_BITS; j++) begin
            act[j] = (BASE + bscf_pkg::CNT_W'(j)) < active_count;
        end
    end

    assign set_hits  = bits_reg & act;
    assign zero_hits = ~bits_reg & act;

    always_comb begin
        set_pos  = '0;
        zero_pos = '0;
        for (int j = bscf_pkg::CELL_BITS - 1; j >= 0; j--) begin
            if (set_hits[j]) begin
                set_pos = bscf_pkg::SUB_W'(j);
            end
            if (zero_hits[j]) begin
                zero_pos = bscf_pkg::SUB_W'(j);
            end
        end
    end

    // Search step: keep the earliest hit seen down the chain and read the tested bit in its own cell
    always_comb begin
        rec_next = scan_in;
        if (!scan_in.set_found && (|set_hits)) begin
            rec_next.set_found = 1'b1;
            rec_next.first_set = {MY_ID, set_pos};
        end
        if (!scan_in.zero_found && (|zero_hits)) begin
            rec_next.zero_found = 1'b1;
            rec_next.first_zero = {MY_ID, zero_pos};
        end
        if (scan_in.test &&
            scan_in.test_idx[bscf_pkg::IDX_W-1:bscf_pkg::SUB_W] == MY_ID) begin
            rec_next.bit_value = bits_reg[scan_in.test_idx[bscf_pkg::SUB_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            bits_reg  <= bits_next;
            valid_reg <= scan_in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign scan_out_valid = valid_reg;
    assign scan_out       = rec_reg;

endmodule

`default_nettype wire

### src/bscf_ctrl.sv
// ----------------------------------------------------------------------------
// bscf_ctrl
// Transaction control: accepts a request, launches the scan, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bscf_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [bscf_pkg::FUNC_W-1:0]  s_func,
    input  wire logic [bscf_pkg::IDX_W-1:0]   s_bit_index,
    input  wire logic [bscf_pkg::CNT_W-1:0]   active_count,
    output bscf_pkg::wr_t                     wr,
    output logic                              start_valid,
    output bscf_pkg::scan_t                   start_rec,
    input  wire logic                         done_valid,
    input  wire bscf_pkg::scan_t              done_rec,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_index_ok,
    output logic                              m_bit_value,
    output logic [bscf_pkg::IDX_W-1:0]        m_first_set,
    output logic                              m_set_found,
    output logic [bscf_pkg::IDX_W-1:0]        m_first_zero,
    output logic                              m_zero_found
);

    bscf_pkg::state_t state_reg, state_next;
    logic             accept;
    logic             ok;
    logic             ok_reg;
    logic             start_valid_reg;
    bscf_pkg::scan_t  start_rec_reg, start_rec_next;
    bscf_pkg::scan_t  res_reg;

    assign ok = {1'b0, s_bit_index} < active_count;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bscf_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = bscf_pkg::ST_SCAN;
                end
            end
            bscf_pkg::ST_SCAN: begin
                if (done_valid) begin
                    state_next = bscf_pkg::ST_DONE;
                end
            end
            bscf_pkg::ST_DONE: begin
                if (m_ready) begin
                    state_next = bscf_pkg::ST_IDLE;
                end
            end
            default: state_next = bscf_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            bscf_pkg::ST_IDLE: s_ready = 1'b1;
            bscf_pkg::ST_DONE: m_valid = 1'b1;
            default: begin
                s_ready = 1'b0;
                m_valid = 1'b0;
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    // Write broadcast takes effect at the accepting edge
    always_comb begin
        wr.en  = accept && ok &&
                 (s_func == bscf_pkg::FUNC_SET || s_func == bscf_pkg::FUNC_CLEAR);
        wr.idx = s_bit_index;
        wr.val = (s_func == bscf_pkg::FUNC_SET);
    end

    always_comb begin
        start_rec_next            = '0;
        start_rec_next.test       = ok && (s_func == bscf_pkg::FUNC_TEST);
        start_rec_next.test_idx   = s_bit_index;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= bscf_pkg::ST_IDLE;
            start_valid_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            start_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            start_rec_reg <= start_rec_next;
            ok_reg        <= ok;
        end
        if (state_reg == bscf_pkg::ST_SCAN && done_valid) begin
            res_reg <= done_rec;
        end
    end

    assign start_valid  = start_valid_reg;
    assign start_rec    = start_rec_reg;
    assign m_index_ok   = ok_reg;
    assign m_bit_value  = res_reg.bit_value;
    assign m_first_set  = res_reg.first_set;
    assign m_set_found  = res_reg.set_found;
    assign m_first_zero = res_reg.first_zero;
    assign m_zero_found = res_reg.zero_found;

endmodule

`default_nettype wire

### src/bitmap_set_clear_find_first.sv
// ----------------------------------------------------------------------------
// bitmap_set_clear_find_first
// Bit store with set, clear and test by index and find-first-set/zero search.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready, s_func, s_bit_index) carries one request
//   per transaction: set, clear or test one bit, or query only. An index at
//   or beyond the active count is refused and the store is left alone.
//   Result channel (m_valid/m_ready) returns one transaction per request:
//   index_ok, the tested bit, and the lowest set and lowest clear index in
//   the active range after the operation, each with a found flag.
//   cfg_wr_en/cfg_wr_data set the active bit count; write only while idle.
//   The store is held in NUM_CELLS byte cells, NUM_CELLS being
//   min(MAX_BITS, 256) / 8 rounded up. The search record walks the
//   chain of byte cells one cell per cycle. One request is in flight
//   at a time; s_ready returns the cycle after the result transaction,
//   so no new request is taken before the last result has gone. When
//   the receiver stalls, the result is held and no new request is taken.
//   Reset clears the whole store and sets the active count to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_set_clear_find_first #(
    parameter int MAX_BITS = bscf_pkg::MAX_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration
    input  wire logic                         cfg_wr_en,
    input  wire logic [bscf_pkg::CNT_W-1:0]   cfg_wr_data,
    // request channel
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [bscf_pkg::FUNC_W-1:0]  s_func,
    input  wire logic [bscf_pkg::IDX_W-1:0]   s_bit_index,
    // result channel
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_index_ok,
    output logic                              m_bit_value,
    output logic [bscf_pkg::IDX_W-1:0]        m_first_set,
    output logic                              m_set_found,
    output logic [bscf_pkg::IDX_W-1:0]        m_first_zero,
    output logic                              m_zero_found
);

    // Bits beyond the index span can never be reached, so hold only the bits inside it
    localparam int EFF_SPAN  = (MAX_BITS < bscf_pkg::ADDR_SPAN) ?
                               MAX_BITS : bscf_pkg::ADDR_SPAN;
    localparam int NUM_CELLS = (EFF_SPAN + bscf_pkg::CELL_BITS - 1) /
                               bscf_pkg::CELL_BITS;
    localparam logic [bscf_pkg::CNT_W-1:0] SPAN_CNT = bscf_pkg::CNT_W'(EFF_SPAN);
    localparam logic [bscf_pkg::CNT_W-1:0] RST_CNT  =
        bscf_pkg::CNT_W'(bscf_pkg::ADDR_SPAN);

    logic [bscf_pkg::CNT_W-1:0] active_bits_reg, active_bits_next;
    logic [bscf_pkg::CNT_W-1:0] active_count;
    bscf_pkg::wr_t              wr;
    logic                       chain_valid [0:NUM_CELLS];
    bscf_pkg::scan_t            chain_rec   [0:NUM_CELLS];

    // Active count register
    always_comb begin
        active_bits_next = active_bits_reg;
        if (cfg_wr_en) begin
            active_bits_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_bits_reg <= RST_CNT;
        end else begin
            active_bits_reg <= active_bits_next;
        end
    end

    // Clamp the count to what the store really holds
    assign active_count = (active_bits_reg > SPAN_CNT) ? SPAN_CNT : active_bits_reg;

    bscf_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_bit_index  (s_bit_index),
        .active_count (active_count),
        .wr           (wr),
        .start_valid  (chain_valid[0]),
        .start_rec    (chain_rec[0]),
        .done_valid   (chain_valid[NUM_CELLS]),
        .done_rec     (chain_rec[NUM_CELLS]),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_index_ok   (m_index_ok),
        .m_bit_value  (m_bit_value),
        .m_first_set  (m_first_set),
        .m_set_found  (m_set_found),
        .m_first_zero (m_first_zero),
        .m_zero_found (m_zero_found)
    );

    // Chain of byte cells; the search record advances one cell per cycle
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        bscf_cell #(
            .CELL_ID (k)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .wr             (wr),
            .active_count   (active_count),
            .scan_in_valid  (chain_valid[k]),
            .scan_in        (chain_rec[k]),
            .scan_out_valid (chain_valid[k+1]),
            .scan_out       (chain_rec[k+1])
        );
    end

endmodule

`default_nettype wire
